// File: rtl/dag_pkg.sv
package dag_pkg;

    localparam int unsigned COORD_W = 24;
    localparam int unsigned DIFF_W = 25;
    localparam int unsigned SQ_W = 50;
    localparam int unsigned SUM_W = 52;
    localparam int unsigned DIST_W = 26;
    localparam int unsigned GAIN_W = 17;
    localparam int unsigned NUM_W = 48;
    localparam int unsigned DEN_W = 43;
    localparam logic [GAIN_W-1:0] GAIN_ONE = 17'h10000;

    typedef enum logic [1:0] {
        REGION_FULL    = 2'd0,
        REGION_ROLLOFF = 2'd1,
        REGION_BEYOND  = 2'd2,
        REGION_ZERODEN = 2'd3
    } region_t;

    typedef struct packed {
        logic [7:0]         source_index;
        logic               playing;
        logic signed [23:0] listener_x;
        logic signed [23:0] listener_y;
        logic signed [23:0] listener_z;
        logic signed [23:0] source_x;
        logic signed [23:0] source_y;
        logic signed [23:0] source_z;
        logic [23:0]        max_distance;
        logic [23:0]        reference_distance;
        logic [15:0]        rolloff;
    } in_item_t;

    typedef struct packed {
        logic [7:0]        result_index;
        logic [GAIN_W-1:0] gain;
        logic [1:0]        region;
    } out_item_t;

    // values carried alongside the data path
    typedef struct packed {
        logic [7:0]  index;
        logic [23:0] maxd;
        logic [23:0] refd;
        logic [15:0] roll;
    } side_t;

endpackage

// File: rtl/distance_attenuation_gain.sv
// Pipeline from input transfer to result: 2 front, 26 root, 2 setup,
//   48 divide stages and 1 output register.
// Throughput: one item per cycle; the pipeline stalls as one unit.
// Reset: rst_n asynchronous, active low; clears all valid bits and sets
//   enable_reg to 1.
module distance_attenuation_gain #(
    parameter int MAX_SOURCES = 256
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  dag_pkg::in_item_t     in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output dag_pkg::out_item_t    out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_data
);
    localparam int unsigned IDX_W = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;

    logic enable_reg;
    logic advance;

    // The whole pipe advances unless a finished result sits in the output
    // register and downstream stalls. The output register is the skid point.
    assign advance   = !(out_valid && out_stall);
    assign in_stall  = !advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            enable_reg <= 1'b1;
        else if (cfg_valid && cfg_ready)
            enable_reg <= cfg_data;
    end

    // Stage 1: absolute differences. Filter disabled / silent items here.
    logic                        s1_vld_reg;
    logic [dag_pkg::DIFF_W-1:0]  dx_reg, dy_reg, dz_reg;
    dag_pkg::side_t              s1_side_reg;
    logic                        take;

    assign take = in_valid && advance && enable_reg && in_data.playing;

    function automatic logic [dag_pkg::DIFF_W-1:0] absdiff(
        input logic signed [23:0] a,
        input logic signed [23:0] b
    );
        logic signed [24:0] d;
        d = 25'(a) - 25'(b);
        return d[24] ? 25'(-d) : 25'(d);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_vld_reg <= 1'b0;
        else if (advance)
            s1_vld_reg <= take;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            dx_reg <= absdiff(in_data.listener_x, in_data.source_x);
            dy_reg <= absdiff(in_data.listener_y, in_data.source_y);
            dz_reg <= absdiff(in_data.listener_z, in_data.source_z);
            s1_side_reg.index <= {{(8 - IDX_W){1'b0}}, in_data.source_index[IDX_W-1:0]};
            s1_side_reg.maxd  <= in_data.max_distance;
            s1_side_reg.refd  <= in_data.reference_distance;
            s1_side_reg.roll  <= in_data.rolloff;
        end
    end

    // Stage 2: squares (25x25 each), registered before the sum.
    logic                       s2_vld_reg;
    logic [dag_pkg::SQ_W-1:0]   sqx_reg, sqy_reg, sqz_reg;
    dag_pkg::side_t             s2_side_reg;
    logic [dag_pkg::SUM_W-1:0]  sum_sq;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_vld_reg <= 1'b0;
        else if (advance)
            s2_vld_reg <= s1_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sqx_reg     <= dx_reg * dx_reg;
            sqy_reg     <= dy_reg * dy_reg;
            sqz_reg     <= dz_reg * dz_reg;
            s2_side_reg <= s1_side_reg;
        end
    end

    assign sum_sq = dag_pkg::SUM_W'(sqx_reg) + dag_pkg::SUM_W'(sqy_reg)
                  + dag_pkg::SUM_W'(sqz_reg);

    logic                        rt_vld;
    logic [dag_pkg::DIST_W-1:0]  src_dist;
    dag_pkg::side_t              rt_side;

    dag_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (s2_vld_reg),
        .radicand  (sum_sq),
        .in_side   (s2_side_reg),
        .out_valid (rt_vld),
        .root      (src_dist),
        .out_side  (rt_side)
    );

    // Setup stage A: region decision and d - ref.
    logic                         sa_vld_reg;
    logic [1:0]                   sa_region_reg;
    logic [dag_pkg::DIST_W-1:0]   sa_excess_reg;
    dag_pkg::side_t               sa_side_reg;
    logic [1:0]                   region_a;

    always_comb
    begin
        priority if (src_dist > dag_pkg::DIST_W'(rt_side.maxd))
            region_a = dag_pkg::REGION_BEYOND;
        else if (src_dist > dag_pkg::DIST_W'(rt_side.refd))
            region_a = dag_pkg::REGION_ROLLOFF;
        else
            region_a = dag_pkg::REGION_FULL;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sa_vld_reg <= 1'b0;
        else if (advance)
            sa_vld_reg <= rt_vld;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sa_region_reg <= region_a;
            sa_excess_reg <= src_dist - dag_pkg::DIST_W'(rt_side.refd);
            sa_side_reg   <= rt_side;
        end
    end

    // Setup stage B: denominator (16x26 product) and fixed-gain cases.
    logic                          sb_vld_reg;
    logic [1:0]                    sb_region_reg;
    logic [dag_pkg::DEN_W-1:0]     sb_den_reg;
    logic [dag_pkg::NUM_W-1:0]     sb_num_reg;
    logic [dag_pkg::GAIN_W-1:0]    sb_fixed_reg;
    logic [7:0]                    sb_index_reg;
    logic [dag_pkg::DEN_W-1:0]     den_b;
    logic [1:0]                    region_b;

    always_comb
    begin
        den_b = (dag_pkg::DEN_W'(sa_side_reg.refd) << 8)
              + dag_pkg::DEN_W'(sa_side_reg.roll) * dag_pkg::DEN_W'(sa_excess_reg);
        region_b = sa_region_reg;
        if (sa_region_reg == dag_pkg::REGION_ROLLOFF && den_b == '0)
            region_b = dag_pkg::REGION_ZERODEN;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sb_vld_reg <= 1'b0;
        else if (advance)
            sb_vld_reg <= sa_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sb_region_reg <= region_b;
            sb_den_reg    <= den_b;
            sb_num_reg    <= dag_pkg::NUM_W'(sa_side_reg.refd) << 24;
            sb_fixed_reg  <= (sa_region_reg == dag_pkg::REGION_FULL) ? dag_pkg::GAIN_ONE
                                                                     : '0;
            sb_index_reg  <= sa_side_reg.index;
        end
    end

    logic               dv_vld;
    dag_pkg::out_item_t dv_item;

    dag_divider u_divider (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .in_valid   (sb_vld_reg),
        .numer      (sb_num_reg),
        .denom      (sb_den_reg),
        .fixed_gain (sb_fixed_reg),
        .in_region  (sb_region_reg),
        .in_index   (sb_index_reg),
        .out_valid  (dv_vld),
        .out_item   (dv_item)
    );

    // Output register: holds its transfer while downstream stalls.
    logic               ov_reg;
    dag_pkg::out_item_t od_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (advance)
            ov_reg <= dv_vld;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            od_reg <= dv_item;
    end

    assign out_valid = ov_reg;
    assign out_data  = od_reg;

    // A stalled result stays put.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed under stall");

    // Input is stalled exactly when a result waits.
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("input stall mismatch");

    // Full region always carries unity gain.
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.region == dag_pkg::REGION_FULL |->
        out_data.gain == dag_pkg::GAIN_ONE)
        else $error("full region gain wrong");

    // A disabled block launches nothing into the pipe.
    a_off: assert property (@(posedge clk) disable iff (!rst_n)
        !enable_reg && advance |=> !s1_vld_reg)
        else $error("item taken while disabled");
endmodule

// File: rtl/dag_isqrt.sv
// Pipelined restoring square root, one result bit per stage.
module dag_isqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  logic                          in_valid,
    input  logic [dag_pkg::SUM_W-1:0]     radicand,
    input  dag_pkg::side_t                in_side,
    output logic                          out_valid,
    output logic [dag_pkg::DIST_W-1:0]    root,
    output dag_pkg::side_t                out_side
);
    localparam int unsigned STAGES = dag_pkg::DIST_W;
    localparam int unsigned SW = dag_pkg::SUM_W;
    localparam int unsigned RW = dag_pkg::DIST_W;

    logic [SW-1:0]   rem_reg  [STAGES+1];
    logic [RW-1:0]   root_reg [STAGES+1];
    logic [STAGES:0] vld_reg;
    dag_pkg::side_t  side_reg [STAGES+1];

    always_comb
    begin
        rem_reg[0]  = radicand;
        root_reg[0] = '0;
        vld_reg[0]  = in_valid;
        side_reg[0] = in_side;
    end

    for (genvar s = 0; s < STAGES; s++) begin : g_stage
        localparam int unsigned B = STAGES - 1 - s;
        logic [SW+1:0] trial;
        logic [SW+1:0] rem_ext;
        logic [RW-1:0] root_next;
        logic [SW-1:0] rem_next;
        always_comb
        begin
            // growth of the square when bit B is set: (r << (B+1)) + (1 << 2B)
            trial = ((SW+2)'(root_reg[s]) << (B + 1)) + ((SW+2)'(1) << (2 * B));
            rem_ext = (SW+2)'(rem_reg[s]);
            if (rem_ext >= trial)
            begin
                rem_next  = SW'(rem_ext - trial);
                root_next = root_reg[s] | (RW'(1) << B);
            end
            else
            begin
                rem_next  = rem_reg[s];
                root_next = root_reg[s];
            end
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s+1] <= 1'b0;
            else if (advance)
                vld_reg[s+1] <= vld_reg[s];
        end
        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                rem_reg[s+1]  <= rem_next;
                root_reg[s+1] <= root_next;
                side_reg[s+1] <= side_reg[s];
            end
        end
    end

    assign out_valid = vld_reg[STAGES];
    assign root      = root_reg[STAGES];
    assign out_side  = side_reg[STAGES];
endmodule

// File: rtl/dag_divider.sv
// Pipelined restoring divider, one quotient bit per stage, with region tag.
module dag_divider (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  logic                          in_valid,
    input  logic [dag_pkg::NUM_W-1:0]     numer,
    input  logic [dag_pkg::DEN_W-1:0]     denom,
    input  logic [dag_pkg::GAIN_W-1:0]    fixed_gain,
    input  logic [1:0]                    in_region,
    input  logic [7:0]                    in_index,
    output logic                          out_valid,
    output dag_pkg::out_item_t            out_item
);
    localparam int unsigned QW = dag_pkg::NUM_W;
    localparam int unsigned DW = dag_pkg::DEN_W;

    typedef struct packed {
        logic [1:0]                 region;
        logic [7:0]                 index;
        logic [dag_pkg::GAIN_W-1:0] fixed;
    } tag_t;

    logic [QW-1:0] quo_reg [QW+1];
    logic [DW-1:0] rem_reg [QW+1];
    logic [DW-1:0] den_reg [QW+1];
    tag_t          tag_reg [QW+1];
    logic [QW:0]   vld_reg;
    logic [QW-1:0] q;

    always_comb
    begin
        quo_reg[0] = numer;
        rem_reg[0] = '0;
        den_reg[0] = denom;
        tag_reg[0] = '{region: in_region, index: in_index, fixed: fixed_gain};
        vld_reg[0] = in_valid;
    end

    for (genvar s = 0; s < QW; s++) begin : g_stage
        logic [DW:0]   shifted;
        logic [DW-1:0] rem_next;
        logic [QW-1:0] quo_next;
        always_comb
        begin
            shifted = {rem_reg[s], quo_reg[s][QW-1]};
            if (shifted >= {1'b0, den_reg[s]})
            begin
                rem_next = DW'(shifted - {1'b0, den_reg[s]});
                quo_next = {quo_reg[s][QW-2:0], 1'b1};
            end
            else
            begin
                rem_next = DW'(shifted);
                quo_next = {quo_reg[s][QW-2:0], 1'b0};
            end
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s+1] <= 1'b0;
            else if (advance)
                vld_reg[s+1] <= vld_reg[s];
        end
        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                quo_reg[s+1] <= quo_next;
                rem_reg[s+1] <= rem_next;
                den_reg[s+1] <= den_reg[s];
                tag_reg[s+1] <= tag_reg[s];
            end
        end
    end

    assign q = quo_reg[QW];

    always_comb
    begin
        out_item.result_index = tag_reg[QW].index;
        out_item.region       = tag_reg[QW].region;
        if (tag_reg[QW].region == dag_pkg::REGION_ROLLOFF)
            out_item.gain = (q > QW'(dag_pkg::GAIN_ONE)) ? dag_pkg::GAIN_ONE
                                                         : q[dag_pkg::GAIN_W-1:0];
        else
            out_item.gain = tag_reg[QW].fixed;
    end
    assign out_valid = vld_reg[QW];
endmodule
